[rtl/tfn_pkg.sv]
// Package: widths, constants and pipeline payload types for the face normal pipeline.
package tfn_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int NORMAL_WIDTH = 32;
	localparam int IN_BITS = COORD_WIDTH - 1;
	localparam int UNIT_BITS = 30;
	localparam int OUT_FRAC = NORMAL_WIDTH - 2;
	localparam int EDGE_W = COORD_WIDTH;
	localparam int CROSS_W = 64;
	localparam int MAG_W = 32;
	localparam int SQ_W = 64;
	localparam int ROOT_W = 32;
	localparam int Q_W = UNIT_BITS + 1;
	localparam int LZ_W = 7;

	typedef logic signed [IN_BITS-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0] edge_t;
	typedef logic [CROSS_W-1:0] cross_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic signed [NORMAL_WIDTH-1:0] norm_t;

	typedef struct packed {
		logic degen;
		logic last;
		logic [2:0] neg;
	} tag_t;
endpackage

[rtl/tfn_cross.sv]
// Cross product front end: edges, products, differences, magnitudes, register per step.
module tfn_cross (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  tfn_pkg::coord_t [8:0] v,
	input  logic                  last_in,
	output logic                  out_valid,
	output tfn_pkg::cross_t [2:0] mag,
	output tfn_pkg::tag_t         tag
);
	import tfn_pkg::*;

	edge_t a_s1 [3];
	edge_t b_s1 [3];
	logic last_s1, last_s2, last_s3;
	logic signed [CROSS_W-1:0] p_s2 [6];
	cross_t c_s3 [3];
	logic [3:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_s1[i] <= EDGE_W'(v[3+i]) - EDGE_W'(v[i]);
			b_s1[i] <= EDGE_W'(v[6+i]) - EDGE_W'(v[i]);
		end
		last_s1 <= last_in;
		p_s2[0] <= CROSS_W'(a_s1[1]) * CROSS_W'(b_s1[2]);
		p_s2[1] <= CROSS_W'(a_s1[2]) * CROSS_W'(b_s1[1]);
		p_s2[2] <= CROSS_W'(a_s1[2]) * CROSS_W'(b_s1[0]);
		p_s2[3] <= CROSS_W'(a_s1[0]) * CROSS_W'(b_s1[2]);
		p_s2[4] <= CROSS_W'(a_s1[0]) * CROSS_W'(b_s1[1]);
		p_s2[5] <= CROSS_W'(a_s1[1]) * CROSS_W'(b_s1[0]);
		last_s2 <= last_s1;
		for (int i = 0; i < 3; i++) c_s3[i] <= p_s2[2*i] - p_s2[2*i+1];
		last_s3 <= last_s2;
		for (int i = 0; i < 3; i++) begin
			mag[i] <= c_s3[i][CROSS_W-1] ? (~c_s3[i] + 1'b1) : c_s3[i];
			tag.neg[i] <= c_s3[i][CROSS_W-1];
		end
		tag.degen <= (c_s3[0] == '0) && (c_s3[1] == '0) && (c_s3[2] == '0);
		tag.last <= last_s3;
	end

	assign out_valid = vld_q[3];
endmodule

[rtl/tfn_norm.sv]
// Block normalization: leading-one count, shift so the largest magnitude is in [2^30, 2^31).
module tfn_norm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  tfn_pkg::cross_t [2:0] mag,
	input  tfn_pkg::tag_t         tag_in,
	output logic                  out_valid,
	output tfn_pkg::mag_t [2:0]   nmag,
	output tfn_pkg::tag_t         tag_out
);
	import tfn_pkg::*;

	cross_t or_s1;
	cross_t m_s1 [3];
	tag_t tag_s1;
	logic [tfn_pkg::LZ_W-1:0] top_s2;
	cross_t m_s2 [3];
	tag_t tag_s2;
	logic [1:0] vld_q;
	logic [LZ_W-1:0] top_c;

	always_comb begin
		top_c = '0;
		for (int i = 0; i < CROSS_W; i++) begin
			if (or_s1[i]) top_c = LZ_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
		end else begin
			vld_q <= {vld_q[0], in_valid};
			out_valid <= vld_q[1];
		end
	end

	// max's leading one equals leading one of the OR of all magnitudes
	always_ff @(posedge clk) begin
		or_s1 <= mag[0] | mag[1] | mag[2];
		for (int i = 0; i < 3; i++) m_s1[i] <= mag[i];
		tag_s1 <= tag_in;
		top_s2 <= top_c;
		for (int i = 0; i < 3; i++) m_s2[i] <= m_s1[i];
		tag_s2 <= tag_s1;
		for (int i = 0; i < 3; i++) begin
			if (top_s2 >= LZ_W'(UNIT_BITS))
				nmag[i] <= MAG_W'(m_s2[i] >> (top_s2 - LZ_W'(UNIT_BITS)));
			else
				nmag[i] <= MAG_W'(m_s2[i] << (LZ_W'(UNIT_BITS) - top_s2));
		end
		tag_out <= tag_s2;
	end
endmodule

[rtl/tfn_sqrt.sv]
// Sum of squares and a pipelined restoring square root, one result bit per stage.
module tfn_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  tfn_pkg::mag_t [2:0] nmag,
	input  tfn_pkg::tag_t       tag_in,
	output logic                out_valid,
	output tfn_pkg::mag_t [2:0] mag_out,
	output logic [tfn_pkg::ROOT_W-1:0] root,
	output tfn_pkg::tag_t       tag_out
);
	import tfn_pkg::*;

	localparam int NST = ROOT_W;

	logic [SQ_W-1:0] sq_s1 [3];
	mag_t m_s1 [3];
	tag_t tag_s1;
	logic v_s1;
	logic [SQ_W-1:0] s_s2;
	mag_t m_s2 [3];
	tag_t tag_s2;
	logic v_s2;

	logic [SQ_W-1:0] rem_q [NST+1];
	logic [ROOT_W-1:0] res_q [NST+1];
	mag_t m_q [NST+1][3];
	tag_t tag_q [NST+1];
	logic [NST:1] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vld_q <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			vld_q <= {vld_q[NST-1:1], v_s2};
		end
	end
	assign rem_q[0] = s_s2;
	assign res_q[0] = '0;
	assign m_q[0] = m_s2;
	assign tag_q[0] = tag_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s1[i] <= SQ_W'(nmag[i]) * SQ_W'(nmag[i]);
			m_s1[i] <= nmag[i];
		end
		tag_s1 <= tag_in;
		s_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		m_s2 <= m_s1;
		tag_s2 <= tag_s1;
	end

	// trial = (4*root_so_far + 1) << 2B
	for (genvar k = 0; k < NST; k++) begin : g_root
		localparam int B = NST - 1 - k;
		logic [SQ_W+1:0] trial;
		always_comb trial = (SQ_W+2)'({res_q[k], 2'b01}) << B << B;
		always_ff @(posedge clk) begin
			m_q[k+1] <= m_q[k];
			tag_q[k+1] <= tag_q[k];
			if ((SQ_W+2)'(rem_q[k]) >= trial) begin
				rem_q[k+1] <= rem_q[k] - SQ_W'(trial);
				res_q[k+1] <= {res_q[k][ROOT_W-2:0], 1'b1};
			end else begin
				rem_q[k+1] <= rem_q[k];
				res_q[k+1] <= {res_q[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_q[NST];
	assign root = res_q[NST];
	assign tag_out = tag_q[NST];
	always_comb for (int i = 0; i < 3; i++) mag_out[i] = m_q[NST][i];
endmodule

[rtl/tfn_div.sv]
// Three pipelined restoring dividers, one quotient bit per stage, then sign and scaling.
module tfn_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  tfn_pkg::mag_t [2:0] mag,
	input  logic [tfn_pkg::ROOT_W-1:0] root,
	input  tfn_pkg::tag_t       tag_in,
	output logic                out_valid,
	output tfn_pkg::norm_t [2:0] normal,
	output logic                degen,
	output logic                last
);
	import tfn_pkg::*;

	localparam int NST = Q_W;
	localparam int R_W = ROOT_W + 1;

	logic [R_W-1:0] rem_q [NST+1][3];
	logic [Q_W-1:0] q_q [NST+1][3];
	logic [ROOT_W-1:0] d_q [NST+1];
	tag_t tag_q [NST+1];
	logic [NST:1] vld_q;
	logic [NORMAL_WIDTH-1:0] sc [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rem_q[0][i] = '0;
			q_q[0][i] = '0;
		end
		d_q[0] = (root == '0) ? ROOT_W'(1) : root;
		tag_q[0] = tag_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
		end else begin
			vld_q <= {vld_q[NST-1:1], in_valid};
			out_valid <= vld_q[NST];
		end
	end

	// numerator mag*2^30 fits in 62 bits; quotient < 2^31, so top 31 bits of num always
	// leave remainder < root: first 31 bits of numerator preload the remainder
	for (genvar k = 0; k < NST; k++) begin : g_div
		always_ff @(posedge clk) begin
			d_q[k+1] <= d_q[k];
			tag_q[k+1] <= tag_q[k];
			for (int i = 0; i < 3; i++) begin
				logic [R_W-1:0] sh;
				if (k < 1) begin
					sh = R_W'(mag[i]);
				end else begin
					sh = {rem_q[k][i][R_W-2:0], 1'b0};
				end
				if (sh >= R_W'(d_q[k])) begin
					rem_q[k+1][i] <= sh - R_W'(d_q[k]);
					q_q[k+1][i] <= {q_q[k][i][Q_W-2:0], 1'b1};
				end else begin
					rem_q[k+1][i] <= sh;
					q_q[k+1][i] <= {q_q[k][i][Q_W-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (OUT_FRAC >= UNIT_BITS)
				sc[i] = NORMAL_WIDTH'(NORMAL_WIDTH'(q_q[NST][i]) << (OUT_FRAC - UNIT_BITS));
			else
				sc[i] = NORMAL_WIDTH'(q_q[NST][i] >> (UNIT_BITS - OUT_FRAC));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (tag_q[NST].degen)
				normal[i] <= '0;
			else if (tag_q[NST].neg[i])
				normal[i] <= norm_t'(~sc[i] + 1'b1);
			else
				normal[i] <= norm_t'(sc[i]);
		end
		degen <= tag_q[NST].degen;
		last <= tag_q[NST].last;
	end
endmodule

[rtl/triangle_face_normal.sv]
// Top level: triangle face normal pipeline, cross product to unit normal in Q1.30.
//  channel | handshake          | payload
//  input   | start, busy        | first/second/third_x/y/z, last_in
//  result  | done (one cycle)   | normal_x/y/z, degenerate, last_out
// One triangle enters every cycle; busy is held low.
// The pipeline runs cross product, block shift, square root and divider in that order.
// Reset clears only the valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline never stops.
module triangle_face_normal (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  tfn_pkg::coord_t         first_x,
	input  tfn_pkg::coord_t         first_y,
	input  tfn_pkg::coord_t         first_z,
	input  tfn_pkg::coord_t         second_x,
	input  tfn_pkg::coord_t         second_y,
	input  tfn_pkg::coord_t         second_z,
	input  tfn_pkg::coord_t         third_x,
	input  tfn_pkg::coord_t         third_y,
	input  tfn_pkg::coord_t         third_z,
	input  logic                    last_in,
	output logic                    done,
	output tfn_pkg::norm_t          normal_x,
	output tfn_pkg::norm_t          normal_y,
	output tfn_pkg::norm_t          normal_z,
	output logic                    degenerate,
	output logic                    last_out
);
	import tfn_pkg::*;

	coord_t [8:0] v;
	logic v1, v2, v3;
	cross_t [2:0] m1;
	mag_t [2:0] m2, m3;
	tag_t t1, t2, t3;
	logic [ROOT_W-1:0] r3;
	norm_t [2:0] nrm;

	assign busy = 1'b0;
	assign v = {third_z, third_y, third_x, second_z, second_y, second_x,
		first_z, first_y, first_x};

	tfn_cross u_cross (.clk, .arst_n, .in_valid(start), .v, .last_in,
		.out_valid(v1), .mag(m1), .tag(t1));
	tfn_norm u_norm (.clk, .arst_n, .in_valid(v1), .mag(m1), .tag_in(t1),
		.out_valid(v2), .nmag(m2), .tag_out(t2));
	tfn_sqrt u_sqrt (.clk, .arst_n, .in_valid(v2), .nmag(m2), .tag_in(t2),
		.out_valid(v3), .mag_out(m3), .root(r3), .tag_out(t3));
	tfn_div u_div (.clk, .arst_n, .in_valid(v3), .mag(m3), .root(r3), .tag_in(t3),
		.out_valid(done), .normal(nrm), .degen(degenerate), .last(last_out));

	assign normal_x = nrm[0];
	assign normal_y = nrm[1];
	assign normal_z = nrm[2];
endmodule
